>>> hdl/gbma_pkg.sv
// shared widths, constants and types of the gyro bias moving average block
`timescale 1ns / 1ps
`default_nettype none

package gbma_pkg;

  localparam int AXES       = 3;
  localparam int RAW_W      = 16;
  localparam int ENTRY_W    = RAW_W + 1;
  localparam int WIN_MAX    = 16;
  localparam int SUM_W      = ENTRY_W + $clog2(WIN_MAX);
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = SUM_W + GAIN_W;
  localparam int SHIFT      = 8;
  localparam int MAG_W      = PROD_W - SHIFT;
  localparam int OUT_W      = 25;
  localparam int CAL_W      = 11;
  localparam int CAL_SUM_W  = 28;

  localparam int DEF_CAL_SAMPLES = 2000;
  localparam int DEF_WINDOW      = 10;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4000;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [SUM_W-1:0] wsum_t;
  typedef logic signed [OUT_W-1:0] out_t;

  typedef struct packed {
    raw_t x;
    raw_t y;
    raw_t z;
  } bias_t;

  typedef struct packed {
    wsum_t x;
    wsum_t y;
    wsum_t z;
  } wsum_vec_t;

  typedef struct packed {
    logic calibrating;
    logic running;
  } cal_stat_t;

endpackage

`default_nettype wire

>>> hdl/gbma_if.sv
// valid/ready channel interfaces for the sample and result streams
`timescale 1ns / 1ps
`default_nettype none

interface gbma_in_if;
  logic                valid;
  logic                ready;
  gbma_pkg::raw_t      rate_x_raw;
  gbma_pkg::raw_t      rate_y_raw;
  gbma_pkg::raw_t      rate_z_raw;
  logic                read_ok;

  modport source (output valid, output rate_x_raw, output rate_y_raw, output rate_z_raw,
                  output read_ok, input ready);
  modport sink   (input valid, input rate_x_raw, input rate_y_raw, input rate_z_raw,
                  input read_ok, output ready);
endinterface

interface gbma_out_if;
  logic                valid;
  logic                ready;
  gbma_pkg::out_t      rate_x_avg;
  gbma_pkg::out_t      rate_y_avg;
  gbma_pkg::out_t      rate_z_avg;

  modport source (output valid, output rate_x_avg, output rate_y_avg, output rate_z_avg,
                  input ready);
  modport sink   (input valid, input rate_x_avg, input rate_y_avg, input rate_z_avg,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/gbma_cal.sv
// calibration: per-axis sums over the first samples and a reciprocal-multiply bias divide
`timescale 1ns / 1ps
`default_nettype none

module gbma_cal #(
  parameter int CAL_SAMPLES = gbma_pkg::DEF_CAL_SAMPLES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire gbma_pkg::raw_t      rate_x_raw,
  input  wire gbma_pkg::raw_t      rate_y_raw,
  input  wire gbma_pkg::raw_t      rate_z_raw,
  input  wire logic                read_ok,
  output gbma_pkg::cal_stat_t      stat,
  output gbma_pkg::bias_t          bias
);

  localparam int CW     = gbma_pkg::CAL_W;
  localparam int SW     = gbma_pkg::CAL_SUM_W;
  localparam int NA     = gbma_pkg::AXES;
  localparam int RSH    = SW + $clog2(CAL_SAMPLES);
  localparam int RCP_W  = SW + 1;
  localparam int QP_W   = SW + RCP_W;

  localparam logic [1:0] PH_CAL = 2'd0;
  localparam logic [1:0] PH_DIV = 2'd1;
  localparam logic [1:0] PH_RUN = 2'd2;

  localparam logic [CW-1:0]    CAL_LAST = CW'(CAL_SAMPLES - 1);
  // rounded-up reciprocal, exact for every magnitude below 2**SW
  localparam logic [RCP_W-1:0] RECIP    =
    RCP_W'(((longint'(1) <<< RSH) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES));

  logic [1:0]             phase_r;
  logic [CW-1:0]          count_r;
  logic signed [SW-1:0]   sum_r  [NA];
  logic [SW-1:0]          mag_r  [NA];
  logic                   neg_r  [NA];
  gbma_pkg::raw_t         bias_r [NA];

  gbma_pkg::raw_t         raw      [NA];
  logic signed [SW-1:0]   sum_nxt  [NA];
  logic [SW-1:0]          sum_abs  [NA];
  logic [QP_W-1:0]        qprod    [NA];
  logic [SW-1:0]          quo      [NA];
  logic [SW-1:0]          quo_neg  [NA];
  gbma_pkg::raw_t         bias_nxt [NA];

  assign raw[0] = rate_x_raw;
  assign raw[1] = rate_y_raw;
  assign raw[2] = rate_z_raw;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      sum_nxt[a] = read_ok ? (sum_r[a] + SW'(raw[a])) : sum_r[a];
      sum_abs[a] = sum_nxt[a][SW-1] ? $unsigned(-sum_nxt[a]) : $unsigned(sum_nxt[a]);
      // magnitude divided toward zero, sign put back afterwards
      qprod[a]   = QP_W'(mag_r[a]) * QP_W'(RECIP);
      quo[a]     = SW'(qprod[a] >> RSH);
      quo_neg[a] = '0 - quo[a];
      bias_nxt[a] = neg_r[a] ? gbma_pkg::RAW_W'(quo_neg[a])
                             : gbma_pkg::RAW_W'(quo[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CAL;
      count_r <= '0;
      for (int a = 0; a < NA; a++) begin
        sum_r[a]  <= '0;
        bias_r[a] <= '0;
      end
    end else begin
      unique case (phase_r)
        PH_CAL: begin
          if (take) begin
            count_r <= count_r + CW'(1);
            for (int a = 0; a < NA; a++) sum_r[a] <= sum_nxt[a];
            if (count_r == CAL_LAST) begin
              phase_r <= PH_DIV;
              for (int a = 0; a < NA; a++) begin
                mag_r[a] <= sum_abs[a];
                neg_r[a] <= sum_nxt[a][SW-1];
              end
            end
          end
        end
        PH_DIV: begin
          phase_r <= PH_RUN;
          for (int a = 0; a < NA; a++) bias_r[a] <= bias_nxt[a];
        end
        PH_RUN: begin
        end
        default: phase_r <= PH_CAL;
      endcase
    end
  end

  assign stat.calibrating = (phase_r == PH_CAL);
  assign stat.running     = (phase_r == PH_RUN);
  assign bias.x = bias_r[0];
  assign bias.y = bias_r[1];
  assign bias.z = bias_r[2];

endmodule

`default_nettype wire

>>> hdl/gbma_win.sv
// bias correction, sample ring and running window sum per axis
`timescale 1ns / 1ps
`default_nettype none

module gbma_win #(
  parameter int WINDOW = gbma_pkg::DEF_WINDOW
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire gbma_pkg::raw_t      rate_x_raw,
  input  wire gbma_pkg::raw_t      rate_y_raw,
  input  wire gbma_pkg::raw_t      rate_z_raw,
  input  wire gbma_pkg::bias_t     bias,
  output logic                     win_ready,
  output logic                     sum_valid,
  input  wire logic                sum_ready,
  output gbma_pkg::wsum_vec_t      sum
);

  localparam int NA     = gbma_pkg::AXES;
  localparam int EW     = gbma_pkg::ENTRY_W;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic signed [EW-1:0] ring_r [NA][WINDOW];
  logic [SLOT_W-1:0]    slot_r;
  gbma_pkg::wsum_t      sum_r [NA];
  logic                 valid_r;

  gbma_pkg::raw_t       raw     [NA];
  gbma_pkg::raw_t       bias_a  [NA];
  logic signed [EW-1:0] entry   [NA];
  gbma_pkg::wsum_t      sum_nxt [NA];

  assign raw[0]    = rate_x_raw;
  assign raw[1]    = rate_y_raw;
  assign raw[2]    = rate_z_raw;
  assign bias_a[0] = bias.x;
  assign bias_a[1] = bias.y;
  assign bias_a[2] = bias.z;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      entry[a]   = EW'(raw[a]) - EW'(bias_a[a]);
      // running sum: add the new entry, drop the one it overwrites
      sum_nxt[a] = sum_r[a] + gbma_pkg::SUM_W'(entry[a])
                            - gbma_pkg::SUM_W'(ring_r[a][slot_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        sum_r[a] <= '0;
        for (int k = 0; k < WINDOW; k++) ring_r[a][k] <= '0;
      end
    end else begin
      if (take) begin
        for (int a = 0; a < NA; a++) begin
          ring_r[a][slot_r] <= entry[a];
          sum_r[a]          <= sum_nxt[a];
        end
        slot_r  <= (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
        valid_r <= 1'b1;
      end else if (sum_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign win_ready = !valid_r || sum_ready;
  assign sum_valid = valid_r;
  assign sum.x     = sum_r[0];
  assign sum.y     = sum_r[1];
  assign sum.z     = sum_r[2];

endmodule

`default_nettype wire

>>> hdl/gbma_scale.sv
// gain multiply, floor shift, reciprocal divide by the window depth and saturation
`timescale 1ns / 1ps
`default_nettype none

module gbma_scale #(
  parameter int WINDOW = gbma_pkg::DEF_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [gbma_pkg::GAIN_W-1:0]   gain,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire gbma_pkg::wsum_vec_t           sum,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output gbma_pkg::out_t                     avg_x,
  output gbma_pkg::out_t                     avg_y,
  output gbma_pkg::out_t                     avg_z
);

  localparam int NA      = gbma_pkg::AXES;
  localparam int PW      = gbma_pkg::PROD_W;
  localparam int MW      = gbma_pkg::MAG_W;
  localparam int OW      = gbma_pkg::OUT_W;
  localparam int NST     = 4;
  localparam int ST_MAG  = 1;
  localparam int ST_QUO  = 2;
  localparam int ST_OUT  = 3;
  localparam int RSH     = MW + $clog2(WINDOW);
  localparam int RCP_W   = MW + 1;
  localparam int QP_W    = MW + RCP_W;

  // rounded-up reciprocal, exact for every magnitude below 2**MW
  localparam logic [RCP_W-1:0] RECIP   =
    RCP_W'(((longint'(1) <<< RSH) + longint'(WINDOW) - 1) / longint'(WINDOW));
  localparam logic [MW-1:0]    LIM_POS = MW'(2 ** (OW - 1) - 1);
  localparam logic [MW-1:0]    LIM_NEG = MW'(2 ** (OW - 1));
  localparam logic [OW-1:0]    OUT_MAX = {1'b0, {(OW - 1){1'b1}}};
  localparam logic [OW-1:0]    OUT_MIN = {1'b1, {(OW - 1){1'b0}}};

  logic [NST-1:0]         v_r;
  logic signed [PW-1:0]   prod_r  [NA];
  logic [MW-1:0]          mag_r   [NA];
  logic                   neg_m_r [NA];
  logic [MW-1:0]          quo_r   [NA];
  logic                   neg_q_r [NA];
  gbma_pkg::out_t         out_r   [NA];

  logic [NST:0]           en;
  logic [NST-1:0]         v_nxt;
  gbma_pkg::wsum_t        sum_a   [NA];
  logic signed [PW-1:0]   prod    [NA];
  logic [MW-1:0]          shifted [NA];
  logic [MW-1:0]          mag     [NA];
  logic [QP_W-1:0]        qprod   [NA];
  logic [MW-1:0]          quo     [NA];
  logic [MW-1:0]          quo_neg [NA];
  gbma_pkg::out_t         sat     [NA];

  assign sum_a[0] = sum.x;
  assign sum_a[1] = sum.y;
  assign sum_a[2] = sum.z;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) en[i] = !v_r[i] || en[i + 1];
    v_nxt = {v_r[NST-2:0], in_valid};
  end

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      prod[a]    = PW'(sum_a[a]) * PW'($signed({1'b0, gain}));
      // arithmetic shift right by 8 is a floor, then take the magnitude
      shifted[a] = prod_r[a][PW-1:gbma_pkg::SHIFT];
      mag[a]     = prod_r[a][PW-1] ? ('0 - shifted[a]) : shifted[a];
      qprod[a]   = QP_W'(mag_r[a]) * QP_W'(RECIP);
      quo[a]     = MW'(qprod[a] >> RSH);
      quo_neg[a] = '0 - quo_r[a];
      if (!neg_q_r[a] && (quo_r[a] > LIM_POS)) begin
        sat[a] = OUT_MAX;
      end else if (neg_q_r[a] && (quo_r[a] > LIM_NEG)) begin
        sat[a] = OUT_MIN;
      end else begin
        sat[a] = neg_q_r[a] ? OW'(quo_neg[a]) : OW'(quo_r[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      if (en[0]) prod_r[a] <= prod[a];
      if (en[ST_MAG]) begin
        mag_r[a]   <= mag[a];
        neg_m_r[a] <= prod_r[a][PW-1];
      end
      if (en[ST_QUO]) begin
        quo_r[a]   <= quo[a];
        neg_q_r[a] <= neg_m_r[a];
      end
      if (en[ST_OUT]) out_r[a] <= sat[a];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[ST_OUT];
  assign avg_x     = out_r[0];
  assign avg_y     = out_r[1];
  assign avg_z     = out_r[2];

endmodule

`default_nettype wire

>>> hdl/gyro_bias_moving_average_top.sv
// top level of the gyro bias calibration and moving average block
// After reset the block takes CAL_SAMPLES three-axis samples for bias calibration and gives
// no result for them; only samples with read_ok set add to the per-axis sums. A reciprocal
// multiply then forms the biases in state PH_DIV, with in_ch.ready low, once per reset. Then
// every sample gives one result: the bias-corrected sample enters a WINDOW-deep ring whose
// sum is a running sum, so one sample can be accepted every clock cycle unless back-pressure
// fills the scale stages; the registered sum update sets the rate. The sum is scaled by
// rate_gain (Q0.16), floor-shifted by 8, divided by WINDOW toward zero by a reciprocal
// multiply and saturated to 25 bits (Q8 deg/s). A result passes the window sum, product,
// magnitude, quotient and output registers; out_ch back-pressure stalls only full stages.
// The user must write rate_gain via cfg_we/cfg_wdata only while idle; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module gyro_bias_moving_average_top #(
  parameter int CAL_SAMPLES = gbma_pkg::DEF_CAL_SAMPLES,
  parameter int WINDOW      = gbma_pkg::DEF_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gbma_in_if.sink                            in_ch,
  gbma_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [gbma_pkg::GAIN_W-1:0]   cfg_wdata
);

  logic [gbma_pkg::GAIN_W-1:0] rate_gain_r;
  gbma_pkg::cal_stat_t         cal_stat;
  gbma_pkg::bias_t             bias;
  gbma_pkg::wsum_vec_t         win_sum;
  logic                        cal_take;
  logic                        win_take;
  logic                        win_ready;
  logic                        sum_valid;
  logic                        sum_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_gain_r <= gbma_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      rate_gain_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = cal_stat.calibrating || (cal_stat.running && win_ready);
  assign cal_take    = in_ch.valid && cal_stat.calibrating;
  assign win_take    = in_ch.valid && cal_stat.running && win_ready;

  gbma_cal #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_cal (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (cal_take),
    .rate_x_raw (in_ch.rate_x_raw),
    .rate_y_raw (in_ch.rate_y_raw),
    .rate_z_raw (in_ch.rate_z_raw),
    .read_ok    (in_ch.read_ok),
    .stat       (cal_stat),
    .bias       (bias)
  );

  gbma_win #(
    .WINDOW (WINDOW)
  ) u_win (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (win_take),
    .rate_x_raw (in_ch.rate_x_raw),
    .rate_y_raw (in_ch.rate_y_raw),
    .rate_z_raw (in_ch.rate_z_raw),
    .bias       (bias),
    .win_ready  (win_ready),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (win_sum)
  );

  gbma_scale #(
    .WINDOW (WINDOW)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (rate_gain_r),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .sum       (win_sum),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .avg_x     (out_ch.rate_x_avg),
    .avg_y     (out_ch.rate_y_avg),
    .avg_z     (out_ch.rate_z_avg)
  );

`ifndef ASSERT_OFF
  // no request is taken while the bias divide runs
  a_no_take_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (cal_stat.calibrating || cal_stat.running))
    else $error("request accepted during bias division");

  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cal_stat.calibrating && cal_stat.running))
    else $error("calibrating and running at once");

  // nothing can reach the output before calibration is over
  a_no_out_before_run: assert property (@(posedge clk) disable iff (!rst_n)
    !cal_stat.running |-> !out_ch.valid)
    else $error("result before calibration finished");

  a_win_sum_valid: assert property (@(posedge clk) disable iff (!rst_n)
    win_take |=> sum_valid)
    else $error("window sum not presented after a sample");
`endif

endmodule

`default_nettype wire

>>> test/gbma_rate_checker.sv
// watches the sample, result and gain ports, predicts each windowed mean and compares
`timescale 1ns / 1ps

module gbma_rate_checker #(
  parameter int CAL_N = gbma_pkg::DEF_CAL_SAMPLES,
  parameter int WIN   = gbma_pkg::DEF_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gbma_in_if                          in_ch,
  gbma_out_if                         out_ch,
  input  logic                        cfg_we,
  input  logic [gbma_pkg::GAIN_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          pending,
  output int                          results_seen
);

  localparam longint MEAN_HI = (longint'(1) <<< (gbma_pkg::OUT_W - 1)) - 1;
  localparam longint MEAN_LO = -(longint'(1) <<< (gbma_pkg::OUT_W - 1));

  typedef struct packed {
    gbma_pkg::out_t x;
    gbma_pkg::out_t y;
    gbma_pkg::out_t z;
  } avg_vec_t;

  int                          cal_taken;
  longint                      cal_acc  [gbma_pkg::AXES];
  longint                      axis_bias[gbma_pkg::AXES];
  longint                      ring     [gbma_pkg::AXES][WIN];
  int                          slot;
  logic [gbma_pkg::GAIN_W-1:0] gain;
  avg_vec_t                    pending_avgs[$];

  function automatic gbma_pkg::out_t window_mean(int axis);
    longint acc;
    longint mean;
    acc = 0;
    for (int k = 0; k < WIN; k++) acc += ring[axis][k];
    // floor shift by 8, then divide toward zero
    mean = ((acc * longint'(gain)) >>> gbma_pkg::SHIFT) / WIN;
    if (mean > MEAN_HI) mean = MEAN_HI;
    if (mean < MEAN_LO) mean = MEAN_LO;
    return gbma_pkg::out_t'(mean);
  endfunction

  function automatic void take_sample(gbma_pkg::raw_t x, gbma_pkg::raw_t y,
                                      gbma_pkg::raw_t z, logic ok);
    longint smp[gbma_pkg::AXES];
    avg_vec_t avg;
    smp[0] = x;
    smp[1] = y;
    smp[2] = z;
    if (cal_taken < CAL_N) begin
      // failed reads still count toward the calibration length
      if (ok) begin
        for (int a = 0; a < gbma_pkg::AXES; a++) cal_acc[a] += smp[a];
      end
      cal_taken++;
      if (cal_taken == CAL_N) begin
        for (int a = 0; a < gbma_pkg::AXES; a++) axis_bias[a] = cal_acc[a] / CAL_N;
      end
    end else begin
      for (int a = 0; a < gbma_pkg::AXES; a++) ring[a][slot] = smp[a] - axis_bias[a];
      slot = (slot + 1) % WIN;
      avg.x = window_mean(0);
      avg.y = window_mean(1);
      avg.z = window_mean(2);
      pending_avgs.push_back(avg);
    end
  endfunction

  function automatic void check_axis(string axis, gbma_pkg::out_t want, gbma_pkg::out_t got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: rate_%s_avg mismatch: expected %0d, got %0d",
               $time, axis, $signed(want), $signed(got));
    end
  endfunction

  always @(posedge clk) begin
    avg_vec_t want;
    if (!rst_n) begin
      cal_taken = 0;
      slot      = 0;
      gain      = gbma_pkg::GAIN_RESET;
      foreach (cal_acc[a]) cal_acc[a] = 0;
      foreach (axis_bias[a]) axis_bias[a] = 0;
      foreach (ring[a, k]) ring[a][k] = 0;
      pending_avgs.delete();
      fail_count   = 0;
      results_seen = 0;
      pending      = 0;
    end else begin
      if (cfg_we) gain = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        take_sample(in_ch.rate_x_raw, in_ch.rate_y_raw, in_ch.rate_z_raw, in_ch.read_ok);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_avgs.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: expected nothing, got x %0d y %0d z %0d",
                   $time, $signed(out_ch.rate_x_avg), $signed(out_ch.rate_y_avg),
                   $signed(out_ch.rate_z_avg));
        end else begin
          want = pending_avgs.pop_front();
          check_axis("x", want.x, out_ch.rate_x_avg);
          check_axis("y", want.y, out_ch.rate_y_avg);
          check_axis("z", want.z, out_ch.rate_z_avg);
        end
      end
      pending = pending_avgs.size();
    end
  end

endmodule

>>> test/gyro_bias_moving_average_top_tb.sv
// stimulus and verdict for the gyro bias calibration and moving average block
`timescale 1ns / 1ps

module gyro_bias_moving_average_top_tb;

  localparam int CAL_N     = gbma_pkg::DEF_CAL_SAMPLES;
  localparam int WIN       = gbma_pkg::DEF_WINDOW;
  localparam int LAT_GUARD = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_STALL,
    IDLE_BOTH
  } idle_mode_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [gbma_pkg::GAIN_W-1:0] cfg_wdata;
  int                          send_gap_pct;
  int                          stall_pct;
  int                          samples_sent;
  int                          fail_count;
  int                          pending;
  int                          results_seen;
  int                          center[gbma_pkg::AXES];

  gbma_in_if  smp_ch();
  gbma_out_if avg_ch();

  gyro_bias_moving_average_top #(
    .CAL_SAMPLES(CAL_N),
    .WINDOW     (WIN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (smp_ch),
    .out_ch   (avg_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  gbma_rate_checker #(
    .CAL_N(CAL_N),
    .WIN  (WIN)
  ) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (smp_ch),
    .out_ch      (avg_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    avg_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idle(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      IDLE_SEND: begin
        send_gap_pct = 75;
        stall_pct    = 0;
      end
      IDLE_STALL: begin
        send_gap_pct = 0;
        stall_pct    = 75;
      end
      default: begin
        send_gap_pct = 24;
        stall_pct    = 24;
      end
    endcase
  endtask

  function automatic gbma_pkg::raw_t clamp_raw(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return gbma_pkg::raw_t'(v);
  endfunction

  function automatic gbma_pkg::raw_t corner_raw();
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  function automatic gbma_pkg::raw_t near_center(int axis, int spread);
    return clamp_raw(center[axis] + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // entered and left at a falling edge; holds each request until the block takes it
  task automatic send(gbma_pkg::raw_t x, gbma_pkg::raw_t y, gbma_pkg::raw_t z, logic ok);
    while ($urandom_range(99) < send_gap_pct) begin
      smp_ch.valid      <= 1'b0;
      smp_ch.rate_x_raw <= gbma_pkg::raw_t'($urandom);
      smp_ch.rate_y_raw <= gbma_pkg::raw_t'($urandom);
      smp_ch.rate_z_raw <= gbma_pkg::raw_t'($urandom);
      smp_ch.read_ok    <= 1'($urandom);
      @(negedge clk);
    end
    smp_ch.valid      <= 1'b1;
    smp_ch.rate_x_raw <= x;
    smp_ch.rate_y_raw <= y;
    smp_ch.rate_z_raw <= z;
    smp_ch.read_ok    <= ok;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  // stationary sensor with a few garbage reads flagged as failed
  task automatic send_cal_sample();
    if ($urandom_range(99) < 5) begin
      send(gbma_pkg::raw_t'($urandom), gbma_pkg::raw_t'($urandom),
           gbma_pkg::raw_t'($urandom), 1'b0);
    end else begin
      send(near_center(0, 200), near_center(1, 200), near_center(2, 200),
           $urandom_range(99) < 88);
    end
  endtask

  task automatic send_mixed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send(near_center(0, 400), near_center(1, 400), near_center(2, 400),
           $urandom_range(99) < 90);
    end else if (pick < 75) begin
      send(gbma_pkg::raw_t'($urandom), gbma_pkg::raw_t'($urandom),
           gbma_pkg::raw_t'($urandom), 1'($urandom));
    end else begin
      send(corner_raw(), corner_raw(), corner_raw(), 1'($urandom));
    end
  endtask

  // the last request has been taken, so nothing more is offered while draining
  task automatic idle_until_drained();
    smp_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LAT_GUARD) @(negedge clk);
  endtask

  task automatic write_gain(logic [gbma_pkg::GAIN_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    smp_ch.valid      = 1'b0;
    smp_ch.rate_x_raw = '0;
    smp_ch.rate_y_raw = '0;
    smp_ch.rate_z_raw = '0;
    smp_ch.read_ok    = 1'b0;
    avg_ch.ready      = 1'b0;
    send_gap_pct      = 0;
    stall_pct         = 0;
    samples_sent      = 0;
    center[0]         = int'($urandom_range(6000, 30000));
    center[1]         = -int'($urandom_range(6000, 30000));
    center[2]         = int'($urandom_range(600)) - 300;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // calibration: full-scale reads both flagged good and failed, then a steady sensor
    send(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1);
    send(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
    send(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send(16'sh0000, 16'shffff, 16'sh0001, 1'b1);
    send(16'shffff, 16'sh0000, 16'shffff, 1'b1);
    for (int i = 6; i < CAL_N; i++) begin
      set_idle(idle_mode_t'(i * 4 / CAL_N));
      send_cal_sample();
    end

    // gain still at its reset value; first results fill the window
    set_idle(IDLE_NONE);
    repeat (100) send_mixed();

    idle_until_drained();
    write_gain(16'hffff);
    send(16'sh7fff, 16'sh8000, 16'sh0000, 1'b0);
    send(16'sh8000, 16'sh7fff, 16'shffff, 1'b1);
    repeat (WIN) send(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'($urandom));
    repeat (WIN) send(16'sh8000, 16'sh8000, 16'sh8000, 1'($urandom));
    repeat (120) send_mixed();

    idle_until_drained();
    write_gain(16'h0000);
    set_idle(IDLE_SEND);
    repeat (100) send_mixed();

    idle_until_drained();
    write_gain(gbma_pkg::GAIN_W'($urandom));
    set_idle(IDLE_STALL);
    repeat (150) send_mixed();

    idle_until_drained();
    write_gain(16'h0001);
    set_idle(IDLE_BOTH);
    repeat (100) send_mixed();

    idle_until_drained();
    write_gain(gbma_pkg::GAIN_W'($urandom));
    for (int i = 0; i < 150; i++) begin
      set_idle(idle_mode_t'((i / 30) % 4));
      send_mixed();
    end

    smp_ch.valid <= 1'b0;
    idle_until_drained();

    $display("summary: %0d samples sent (%0d for bias calibration), %0d windowed means checked",
             samples_sent, CAL_N, results_seen);
    $display("summary: gain at reset, 0, 1, 65535 and two random values, %s",
             "full-scale bursts and four sender/receiver idle patterns");
    if (fail_count == 0) begin
      $display("gyro_bias_moving_average_top regression: pass");
    end else begin
      $display("gyro_bias_moving_average_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the block");
    $display("gyro_bias_moving_average_top regression: fail");
    $finish;
  end

endmodule

>>> gyro_bias_moving_average_top.f
hdl/gbma_pkg.sv
hdl/gbma_if.sv
hdl/gbma_cal.sv
hdl/gbma_win.sv
hdl/gbma_scale.sv
hdl/gyro_bias_moving_average_top.sv
test/gbma_rate_checker.sv
test/gyro_bias_moving_average_top_tb.sv
